// ===== sv/tlpq_pkg.sv =====
// shared types and constants for the three-level priority queue
// no dependencies

package tlpq_pkg;

    localparam int unsigned CAPACITY_DEF     = 64;
    localparam int unsigned PAYLOAD_BITS_DEF = 16;

    // command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_GET   = 2'd1;
    localparam logic [1:0] CMD_ACCEL = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // priority levels
    localparam logic [1:0] LVL_LOW    = 2'd0;
    localparam logic [1:0] LVL_NORMAL = 2'd1;
    localparam logic [1:0] LVL_HIGH   = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic update;
    } t_ctrl;

endpackage

// ===== sv/tlpq_ctrl.sv =====
// sequencer for the three-level priority queue: accept, update, strobe
// depends on tlpq_pkg

module tlpq_ctrl import tlpq_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_start,
    output logic  o_busy,
    output logic  o_valid,
    output t_ctrl o_ctrl
);

    typedef enum logic {
        S_IDLE,
        S_UPDATE
    } t_state;

    t_state r_state;
    logic   r_busy;
    logic   r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_state <= S_UPDATE;
                        r_busy  <= 1'b1;
                    end
                end
                S_UPDATE: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                    r_valid <= 1'b1;
                end
                default: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
            endcase
        end
    end

    assign o_ctrl.capture = i_start && (r_state == S_IDLE);
    assign o_ctrl.update  = (r_state == S_UPDATE);
    assign o_busy         = r_busy;
    assign o_valid        = r_valid;

endmodule

// ===== sv/tlpq_datapath.sv =====
// node store, level lists and free list of the three-level priority queue
// depends on tlpq_pkg; sequenced by tlpq_ctrl

module tlpq_datapath import tlpq_pkg::*; #(
    parameter int unsigned CAPACITY     = CAPACITY_DEF,
    parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctrl                   i_ctrl,
    input  logic [1:0]              i_cmd,
    input  logic [1:0]              i_level,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic [1:0]              o_status,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [1:0]              o_out_level
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam logic [AW-1:0] LAST    = AW'(CAPACITY - 1);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    // node store
    logic [AW-1:0]           r_mem_next [CAPACITY];
    logic [PAYLOAD_BITS-1:0] r_mem_pay  [CAPACITY];

    // list state
    logic [AW-1:0] r_head  [3];
    logic [AW-1:0] r_tail  [3];
    logic [CW-1:0] r_count [3];
    logic [AW-1:0] r_free_head;
    logic [CW-1:0] r_free_count;
    logic [CW-1:0] r_fill;

    logic [AW-1:0] n_head  [3];
    logic [AW-1:0] n_tail  [3];
    logic [CW-1:0] n_count [3];
    logic [AW-1:0] n_free_head;
    logic [CW-1:0] n_free_count;
    logic [CW-1:0] n_fill;

    // captured item
    logic [1:0]              r_cmd;
    logic [1:0]              r_lv;
    logic                    r_empty;
    logic [AW-1:0]           r_n;
    logic [PAYLOAD_BITS-1:0] r_payload;
    logic [AW-1:0]           r_rd_next;
    logic [PAYLOAD_BITS-1:0] r_rd_pay;

    // result
    logic [1:0]              r_status;
    logic [PAYLOAD_BITS-1:0] r_out_payload;
    logic [1:0]              r_out_level;

    logic [1:0]              lvl_sat;
    logic [1:0]              sel_get;
    logic                    all_empty;
    logic [AW-1:0]           rd_addr;
    logic                    fresh;
    logic                    we_next;
    logic [AW-1:0]           waddr;
    logic [AW-1:0]           wdata;
    logic                    we_pay;
    logic [1:0]              res_status;
    logic [PAYLOAD_BITS-1:0] res_pay;
    logic [1:0]              res_lvl;

    // capture side
    always_comb begin
        lvl_sat   = (i_level > LVL_HIGH) ? LVL_HIGH : i_level;
        all_empty = (r_count[LVL_HIGH] == '0) && (r_count[LVL_NORMAL] == '0)
                    && (r_count[LVL_LOW] == '0);
        if (r_count[LVL_HIGH] != '0) begin
            sel_get = LVL_HIGH;
        end else if (r_count[LVL_NORMAL] != '0) begin
            sel_get = LVL_NORMAL;
        end else begin
            sel_get = LVL_LOW;
        end
        rd_addr = (i_cmd == CMD_GET) ? r_head[sel_get] : r_free_head;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_cmd     <= i_cmd;
            r_lv      <= (i_cmd == CMD_GET) ? sel_get : lvl_sat;
            r_empty   <= all_empty;
            r_n       <= rd_addr;
            r_payload <= i_payload;
            r_rd_next <= r_mem_next[rd_addr];
            r_rd_pay  <= r_mem_pay[rd_addr];
        end
    end

    // update side
    always_comb begin
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_free_head  = r_free_head;
        n_free_count = r_free_count;
        n_fill       = r_fill;
        we_next      = 1'b0;
        waddr        = r_tail[r_lv];
        wdata        = r_n;
        we_pay       = 1'b0;
        res_status   = ST_OK;
        res_pay      = '0;
        res_lvl      = LVL_LOW;
        // nodes at or above the fill mark were never written and still link onward
        fresh        = (CW'(r_n) >= r_fill);

        case (r_cmd)
            CMD_PUT: begin
                if (r_free_count == '0) begin
                    res_status = ST_FULL;
                end else begin
                    if (fresh) begin
                        n_free_head = (r_n == LAST) ? '0 : r_n + AW'(1);
                        n_fill      = r_fill + CW'(1);
                    end else begin
                        n_free_head = r_rd_next;
                    end
                    n_free_count = r_free_count - CW'(1);
                    we_pay       = 1'b1;
                    if (r_count[r_lv] == '0) begin
                        n_head[r_lv] = r_n;
                    end else begin
                        we_next = 1'b1;
                    end
                    n_tail[r_lv]  = r_n;
                    n_count[r_lv] = r_count[r_lv] + CW'(1);
                end
            end
            CMD_GET: begin
                if (r_empty) begin
                    res_status = ST_EMPTY;
                end else begin
                    res_pay       = r_rd_pay;
                    res_lvl       = r_lv;
                    n_head[r_lv]  = r_rd_next;
                    n_count[r_lv] = r_count[r_lv] - CW'(1);
                    we_next       = 1'b1;
                    waddr         = r_n;
                    wdata         = r_free_head;
                    n_free_head   = r_n;
                    n_free_count  = r_free_count + CW'(1);
                end
            end
            CMD_ACCEL: begin
                if (r_count[LVL_LOW] != '0) begin
                    if (r_count[LVL_HIGH] == '0) begin
                        n_head[LVL_HIGH] = r_head[LVL_LOW];
                    end else begin
                        we_next = 1'b1;
                        waddr   = r_tail[LVL_HIGH];
                        wdata   = r_head[LVL_LOW];
                    end
                    n_tail[LVL_HIGH]  = r_tail[LVL_LOW];
                    n_count[LVL_HIGH] = r_count[LVL_HIGH] + r_count[LVL_LOW];
                    n_count[LVL_LOW]  = '0;
                    n_head[LVL_LOW]   = '0;
                    n_tail[LVL_LOW]   = '0;
                end
            end
            default: begin
                res_status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head       <= '{default: '0};
            r_tail       <= '{default: '0};
            r_count      <= '{default: '0};
            r_free_head  <= '0;
            r_free_count <= CAP_CNT;
            r_fill       <= '0;
        end else if (i_ctrl.update) begin
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_free_head  <= n_free_head;
            r_free_count <= n_free_count;
            r_fill       <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.update) begin
            if (we_next) begin
                r_mem_next[waddr] <= wdata;
            end
            if (we_pay) begin
                r_mem_pay[r_n] <= r_payload;
            end
            r_status      <= res_status;
            r_out_payload <= res_pay;
            r_out_level   <= res_lvl;
        end
    end

    assign o_status      = r_status;
    assign o_out_payload = r_out_payload;
    assign o_out_level   = r_out_level;

endmodule

// ===== sv/three_level_priority_queue_accelerate.sv =====
// top level of the three-level priority queue with low-to-high acceleration
// depends on tlpq_pkg, tlpq_ctrl and tlpq_datapath

// Each item (put, get or accelerate) passes through a capture step, in which start
// is taken and the node store is read synchronously, and then an update step in
// which the lists change. The result then sits on the o_ ports for one cycle with
// o_valid high; the receiver cannot stall it, and a new item may start in that
// same cycle, while start is ignored during the update step. busy is high during
// the update cycle only. No clearing pass follows reset: the block takes items
// as soon as reset is released.

module three_level_priority_queue_accelerate import tlpq_pkg::*; #(
    parameter int unsigned CAPACITY     = CAPACITY_DEF,
    parameter int unsigned PAYLOAD_BITS = PAYLOAD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [1:0]              i_cmd,
    input  logic [1:0]              i_level,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    output logic                    o_valid,
    output logic [1:0]              o_status,
    output logic [PAYLOAD_BITS-1:0] o_out_payload,
    output logic [1:0]              o_out_level
);

    t_ctrl ctrl;

    tlpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_valid (o_valid),
        .o_ctrl  (ctrl)
    );

    tlpq_datapath #(
        .CAPACITY     (CAPACITY),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctrl        (ctrl),
        .i_cmd         (i_cmd),
        .i_level       (i_level),
        .i_payload     (i_payload),
        .o_status      (o_status),
        .o_out_payload (o_out_payload),
        .o_out_level   (o_out_level)
    );

endmodule
